/* sv/osm_pkg.sv */
// Package: shared constants and types for the order-statistic multiset.
`timescale 1ns / 1ps
`default_nettype none
package osm_pkg;
    localparam int CAPACITY  = 1024;
    localparam int AW        = $clog2(CAPACITY);
    localparam int CW        = AW + 1;
    localparam logic [15:0] MAX_ITEMS = 16'hFFFF;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_ERASE  = 3'd1,
        REQ_KMIN   = 3'd2,
        REQ_KMAX   = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_RANK   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_DECIDE, S_SHUP_RD, S_SHUP_WR,
        S_SHDN_RD, S_SHDN_WR, S_RANK_RD, S_RANK_CHK, S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic signed [31:0] key_value;
        logic [15:0] rank_k;
    } t_req_word;

    typedef struct packed {
        logic signed [31:0] result_key;
        logic [1:0]  status;
        logic [15:0] item_count;
    } t_rsp_word;
endpackage
`default_nettype wire

/* sv/osm_if.sv */
// Interfaces: valid/ready channels for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface osm_req_if;
    import osm_pkg::*;
    logic      valid;
    logic      ready;
    t_req_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface osm_rsp_if;
    import osm_pkg::*;
    logic      valid;
    logic      ready;
    t_rsp_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/order_statistic_multiset.sv */
// Top level: order-statistic multiset over a sorted key/count table.
//
//   channel  | dir | payload
//   i_req    | in  | req_type, key_value, rank_k
//   o_rsp    | out | result_key, status, item_count
//
// One request at a time. Lookup is a linear scan over the table (one
// memory read port). Insert/erase of a new or last copy then shifts the
// tail entry by entry. Queries sum counts entry by entry. Scan and shift
// together pass over the table once.
// Reset is synchronous; table contents are not cleared. Result stays held
// until taken; the next request is accepted only after that.
`timescale 1ns / 1ps
`default_nettype none
module order_statistic_multiset (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    osm_req_if.sink   i_req,
    osm_rsp_if.source o_rsp
);
    import osm_pkg::*;

    t_state r_state, n_state;
    t_req_word r_req, n_req;
    logic [CW-1:0] r_used, n_used;
    logic [15:0]   r_total, n_total;
    logic [CW-1:0] r_idx, n_idx;    // scan/shift pointer
    logic [CW-1:0] r_pos, n_pos;    // lower bound
    logic          r_found, n_found;
    logic [15:0]   r_cnt, n_cnt;    // multiplicity at r_pos
    logic [15:0]   r_rank, n_rank;
    logic [16:0]   r_acc, n_acc;
    t_rsp_word     r_rsp, n_rsp;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [47:0]   wdata, rdata;
    logic signed [31:0] rkey;
    logic [15:0]   rmul;

    assign rkey = rdata[47:16];
    assign rmul = rdata[15:0];

    osm_table u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_total <= n_total;
        end
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_cnt   <= n_cnt;
        r_rank  <= n_rank;
        r_acc   <= n_acc;
        r_rsp   <= n_rsp;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_DONE);
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_used  = r_used;
        n_total = r_total;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_found = r_found;
        n_cnt   = r_cnt;
        n_rank  = r_rank;
        n_acc   = r_acc;
        n_rsp   = r_rsp;
        we      = 1'b0;
        waddr   = r_idx[AW-1:0];
        wdata   = rdata;
        raddr   = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.data;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_rsp   = '{result_key: '0, status: ST_OK, item_count: r_total};
                    case (i_req.data.req_type)
                        REQ_INSERT, REQ_ERASE: n_state = S_SRCH_RD;
                        REQ_KMIN, REQ_KMAX: begin
                            n_acc = '0;
                            if (i_req.data.rank_k == 16'd0 ||
                                i_req.data.rank_k > r_total) begin
                                n_rsp.status = ST_RANK;
                                n_state = S_DONE;
                            end else begin
                                n_rank  = (i_req.data.req_type == REQ_KMIN) ?
                                          i_req.data.rank_k :
                                          16'(r_total - i_req.data.rank_k + 16'd1);
                                n_state = S_RANK_RD;
                            end
                        end
                        REQ_CLEAR: begin
                            n_used  = '0;
                            n_total = '0;
                            n_rsp.item_count = '0;
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            // linear lower-bound scan
            S_SRCH_RD: begin
                if (r_idx >= r_used) begin
                    n_pos = r_idx;
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                if (rkey < r_req.key_value) begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_SRCH_RD;
                end else begin
                    n_pos   = r_idx;
                    n_found = (rkey == r_req.key_value);
                    n_cnt   = rmul;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_req.req_type == REQ_INSERT) begin
                    if (r_total >= MAX_ITEMS) begin
                        n_rsp.status = ST_FULL;
                    end else if (r_found) begin
                        if (r_cnt == 16'hFFFF) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            we = 1'b1;
                            waddr = r_pos[AW-1:0];
                            wdata = {r_req.key_value, 16'(r_cnt + 16'd1)};
                            n_total = r_total + 16'd1;
                            n_rsp.item_count = n_total;
                        end
                    end else if (r_used >= CW'(CAPACITY)) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        n_idx = r_used;
                        n_state = S_SHUP_RD;
                    end
                end else begin
                    if (!r_found) begin
                        n_rsp.status = ST_ABSENT;
                    end else if (r_cnt > 16'd1) begin
                        we = 1'b1;
                        waddr = r_pos[AW-1:0];
                        wdata = {r_req.key_value, 16'(r_cnt - 16'd1)};
                        n_total = r_total - 16'd1;
                        n_rsp.item_count = n_total;
                    end else begin
                        n_idx = r_pos;
                        n_state = S_SHDN_RD;
                    end
                end
            end
            // open a slot at r_pos: move [i-1] to [i] from the top down
            S_SHUP_RD: begin
                if (r_idx == r_pos) begin
                    we = 1'b1;
                    waddr = r_pos[AW-1:0];
                    wdata = {r_req.key_value, 16'd1};
                    n_used  = r_used + 1'b1;
                    n_total = r_total + 16'd1;
                    n_rsp.item_count = n_total;
                    n_state = S_DONE;
                end else begin
                    raddr = AW'(r_idx - 1'b1);
                    n_state = S_SHUP_WR;
                end
            end
            S_SHUP_WR: begin
                we = 1'b1;
                n_idx = r_idx - 1'b1;
                n_state = S_SHUP_RD;
            end
            // close the slot at r_pos: move [i+1] to [i]
            S_SHDN_RD: begin
                if (CW'(r_idx + 1'b1) >= r_used) begin
                    n_used  = r_used - 1'b1;
                    n_total = r_total - 16'd1;
                    n_rsp.item_count = n_total;
                    n_state = S_DONE;
                end else begin
                    raddr = AW'(r_idx + 1'b1);
                    n_state = S_SHDN_WR;
                end
            end
            S_SHDN_WR: begin
                we = 1'b1;
                n_idx = r_idx + 1'b1;
                n_state = S_SHDN_RD;
            end
            // running sum of counts until it reaches the rank
            S_RANK_RD: n_state = S_RANK_CHK;
            S_RANK_CHK: begin
                n_acc = r_acc + {1'b0, rmul};
                if ({1'b0, r_rank} <= n_acc) begin
                    n_rsp.result_key = rkey;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_RANK_RD;
                end
            end
            S_DONE: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid)) else $error("ready while result pending");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CAPACITY)) else $error("table overflow");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(r_rsp))
        else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

/* sv/osm_table.sv */
// Table memory: sorted keys and multiplicities, one port each way.
`timescale 1ns / 1ps
`default_nettype none
module osm_table (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [osm_pkg::AW-1:0] i_waddr,
    input  wire logic [47:0]           i_wdata,
    input  wire logic [osm_pkg::AW-1:0] i_raddr,
    output      logic [47:0]           o_rdata
);
    import osm_pkg::*;
    logic [47:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
